/* rtl/core/pba_pkg.sv */
// Package for the page bitmap allocator: sizes, opcodes.
package pba_pkg;
    localparam int MaxPages    = 65536;
    localparam int WordBits    = 32;
    localparam int MapWords    = MaxPages / WordBits;
    localparam int WordAw      = $clog2(MapWords);
    localparam int BitAw       = $clog2(WordBits);
    localparam int PageW       = 16;
    localparam int CntW        = 17;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_SET   = 2'd1,
        OP_CLR   = 2'd2,
        OP_RANGE = 2'd3
    } t_op;

    typedef logic [WordBits-1:0] t_word;
endpackage

/* rtl/core/pba_map_ram.sv */
// Bitmap word store: one write port, one registered read port.
module pba_map_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [pba_pkg::WordAw-1:0]  i_waddr,
    input  pba_pkg::t_word              i_wdata,
    input  logic [pba_pkg::WordAw-1:0]  i_raddr,
    output pba_pkg::t_word              o_rdata
);
    pba_pkg::t_word r_mem [pba_pkg::MapWords];
    pba_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/page_bitmap_allocator_unit.sv */
// Top level of the page bitmap allocator.
// Usage:
//  Request channel i_valid/o_ready carries op, page and end_page in one beat.
//  Result channel o_valid/i_ready returns ok and alloc_page, one beat per
//  request, in order. i_cfg_we writes total_pages (17 bits); the user is
//  to write it only while idle, as the block does not enforce this. The
//  bitmap sits in one 2048 x 32 RAM (registered read). A per-word full
//  flag vector (2048 flops) skips full words; allocation finds the lowest
//  non-full word with a 32-word group scan: 64 groups, one per cycle.
//  Mark busy / free: read, modify, write.
//  Range: read, wait and modify for each word from first to last word,
//  then the result beat.
//  Reset (i_rst_n low, synchronous): a clearing pass writes zero to all
//  2048 words, one per cycle, before o_ready rises; total_pages = 65536.
//  When the receiver stalls, the result sits in the output register and
//  the next request waits until it is taken (one request at a time).
module page_bitmap_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_page,
    input  logic [15:0] i_end_page,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic [15:0] o_alloc_page
);
    localparam int Aw = pba_pkg::WordAw;
    localparam int Bw = pba_pkg::BitAw;
    localparam int Groups = pba_pkg::MapWords / 32;
    localparam int Gw = $clog2(Groups);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_READ, S_WAIT, S_MOD, S_OUT
    } t_state;

    t_state r_state;
    logic [Aw-1:0] r_addr, r_last;
    logic [Gw-1:0] r_grp;
    logic [pba_pkg::CntW-1:0] r_total;
    logic [1:0] r_op;
    logic [15:0] r_page, r_end;
    logic r_ok;
    logic [15:0] r_alloc;
    logic [pba_pkg::MapWords-1:0] r_full;

    logic we;
    logic [Aw-1:0] waddr;
    pba_pkg::t_word wdata, rdata;

    pba_map_ram u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(r_addr), .o_rdata(rdata)
    );

    // effective page limit
    logic [pba_pkg::CntW-1:0] limit;
    assign limit = (r_total > pba_pkg::CntW'(pba_pkg::MaxPages))
                 ? pba_pkg::CntW'(pba_pkg::MaxPages) : r_total;

    // group scan: lowest non-full word within current group
    logic [31:0] grp_full;
    logic        grp_hit;
    logic [4:0]  grp_idx;
    always_comb begin
        grp_full = r_full[r_grp*32 +: 32];
        grp_hit = 1'b0;
        grp_idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (!grp_full[i]) begin
                grp_hit = 1'b1;
                grp_idx = 5'(i);
            end
        end
    end

    // lowest free bit in read word
    logic          bit_hit;
    logic [Bw-1:0] bit_idx;
    always_comb begin
        bit_hit = 1'b0;
        bit_idx = '0;
        for (int i = pba_pkg::WordBits-1; i >= 0; i--) begin
            if (!rdata[i]) begin
                bit_hit = 1'b1;
                bit_idx = Bw'(i);
            end
        end
    end

    // word bit masks for the modify step
    logic [pba_pkg::CntW-1:0] found_pg;
    pba_pkg::t_word lo_m, hi_m, mod_word;
    logic [Bw-1:0] pb, eb;
    assign pb = r_page[Bw-1:0];
    assign eb = r_end[Bw-1:0];
    assign found_pg = {1'b0, r_addr, bit_idx};
    always_comb begin
        lo_m = (r_addr == r_page[15:Bw]) ? ('1 << pb) : '1;
        hi_m = (r_addr == r_end[15:Bw]) ? ('1 >> (Bw'(pba_pkg::WordBits-1) - eb)) : '1;
        case (pba_pkg::t_op'(r_op))
            pba_pkg::OP_ALLOC: mod_word = rdata | (pba_pkg::t_word'(1) << bit_idx);
            pba_pkg::OP_SET:   mod_word = rdata | (pba_pkg::t_word'(1) << pb);
            pba_pkg::OP_CLR:   mod_word = rdata & ~(pba_pkg::t_word'(1) << pb);
            default:           mod_word = rdata | (lo_m & hi_m);
        endcase
    end

    assign we    = (r_state == S_CLEAR) || (r_state == S_MOD && r_ok);
    assign waddr = r_addr;
    assign wdata = (r_state == S_CLEAR) ? '0 : mod_word;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_ok = r_ok;
    assign o_alloc_page = r_alloc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_total <= pba_pkg::CntW'(pba_pkg::MaxPages);
            r_full  <= '0;
            r_ok    <= 1'b0;
            r_grp   <= '0;
        end else begin
            if (i_cfg_we) r_total <= i_cfg_wdata;
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == Aw'(pba_pkg::MapWords-1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op   <= i_op;
                        r_page <= i_page;
                        r_end  <= i_end_page;
                        r_alloc <= '0;
                        r_grp  <= '0;
                        r_ok   <= 1'b0;
                        case (pba_pkg::t_op'(i_op))
                            pba_pkg::OP_ALLOC: r_state <= S_SCAN;
                            pba_pkg::OP_RANGE: begin
                                r_addr <= i_page[15:Bw];
                                r_last <= i_end_page[15:Bw];
                                r_ok <= (i_page <= i_end_page)
                                     && ({1'b0, i_end_page} < limit);
                                r_state <= S_READ;
                            end
                            default: begin
                                r_addr <= i_page[15:Bw];
                                r_last <= i_page[15:Bw];
                                r_ok <= ({1'b0, i_page} < limit);
                                r_state <= S_READ;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (grp_hit) begin
                        r_addr  <= {r_grp, grp_idx};
                        r_last  <= {r_grp, grp_idx};
                        r_state <= S_READ;
                    end else if (r_grp == Gw'(Groups-1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_grp <= r_grp + 1'b1;
                    end
                end
                S_READ: r_state <= S_WAIT;
                S_WAIT: begin
                    if (r_op == pba_pkg::OP_ALLOC) begin
                        r_ok <= bit_hit && (found_pg < limit);
                        if (bit_hit && (found_pg < limit))
                            r_alloc <= found_pg[15:0];
                    end
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_ok) r_full[r_addr] <= &mod_word;
                    if (!r_ok || r_addr == r_last) begin
                        r_state <= S_OUT;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* test/page_bitmap_allocator_unit_tb.sv */
// Testbench for the page bitmap allocator: predicted results vs. DUT beats.
`timescale 1ns / 100ps

module page_bitmap_allocator_unit_tb;

    // Expected result beat.
    typedef struct packed {
        logic        ok;
        logic [15:0] alloc_page;
    } t_alloc_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_op;
    logic [15:0] i_page;
    logic [15:0] i_end_page;
    logic        i_cfg_we;
    logic [16:0] i_cfg_wdata;
    logic        o_valid;
    logic        i_ready;
    logic        o_ok;
    logic [15:0] o_alloc_page;

    page_bitmap_allocator_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_page       (i_page),
        .i_end_page   (i_end_page),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ok         (o_ok),
        .o_alloc_page (o_alloc_page)
    );

    // Shadow copy of the DUT state: one busy bit per page plus the page count.
    bit                       busy_pages [pba_pkg::MaxPages];
    logic [pba_pkg::CntW-1:0] total_pages_shadow;

    t_alloc_result   pending_results[$];
    int              fail_count;
    int              send_idle_pct;   // chance in 100 the sender idles a cycle
    int              recv_stall_pct;  // chance in 100 the receiver stalls

    // Clock: 10 ns period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #100ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Effective page limit: counts above MaxPages saturate.
    function automatic int unsigned page_limit();
        return (total_pages_shadow > pba_pkg::MaxPages) ? pba_pkg::MaxPages
                                                        : total_pages_shadow;
    endfunction

    // Applies one request to the shadow bitmap and returns its result beat.
    function automatic t_alloc_result apply_request(pba_pkg::t_op op, logic [15:0] page,
                                                    logic [15:0] end_page);
        t_alloc_result res;
        int unsigned   lim;
        lim = page_limit();
        res = '0;
        case (op)
            pba_pkg::OP_ALLOC: begin
                // First fit: lowest free page below the limit.
                for (int unsigned p = 0; p < lim; p++) begin
                    if (!busy_pages[p]) begin
                        busy_pages[p]  = 1'b1;
                        res.ok         = 1'b1;
                        res.alloc_page = p[15:0];
                        break;
                    end
                end
            end
            pba_pkg::OP_SET, pba_pkg::OP_CLR: begin
                if (page < lim) begin
                    busy_pages[page] = (op == pba_pkg::OP_SET);
                    res.ok           = 1'b1;
                end
            end
            default: begin
                // Range: rejected when reversed or the end is out of range.
                if (page <= end_page && end_page < lim) begin
                    for (int unsigned p = page; p <= end_page; p++)
                        busy_pages[p] = 1'b1;
                    res.ok = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    // Receiver: ready changes on the falling edge, per the stall rate.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checker: every accepted beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: ok=%0d alloc_page=%0d", o_ok, o_alloc_page);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, o_ok);
                    fail_count++;
                end
                if (o_alloc_page !== want.alloc_page) begin
                    $error("alloc_page: expected %0d, got %0d",
                           want.alloc_page, o_alloc_page);
                    fail_count++;
                end
            end
        end
    end

    // Sends one request beat; called and returns at a falling edge.
    task automatic send_request(pba_pkg::t_op op, logic [15:0] page,
                                logic [15:0] end_page);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_op       = op;
        i_page     = page;
        i_end_page = end_page;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // Beat accepted at this edge: predict now so the queue stays in order.
        pending_results.push_back(apply_request(op, page, end_page));
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every expected beat has come back.
    task automatic drain_results();
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes total_pages; only called with the DUT idle.
    task automatic write_total_pages(logic [pba_pkg::CntW-1:0] count);
        drain_results();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = count;
        @(negedge i_clk);
        i_cfg_we           = 1'b0;
        total_pages_shadow = count;
    endtask

    // Page picker that favors the edges of the valid range.
    function automatic logic [15:0] pick_page();
        int unsigned lim;
        lim = page_limit();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom());
            1:       return (lim == 0) ? 16'd0 : 16'(lim - 1);
            2:       return 16'(lim);     // first invalid page (wraps at 64K)
            3:       return 16'($urandom_range(0, 63));
            default: return (lim == 0) ? 16'd0 : 16'($urandom_range(0, lim - 1));
        endcase
    endfunction

    // Extremes, every op, and the listed corner cases.
    task automatic test_directed();
        write_total_pages(17'd65536);
        send_request(pba_pkg::OP_ALLOC, 16'd0, 16'd0);      // first fit from empty: page 0
        send_request(pba_pkg::OP_ALLOC, 16'hFFFF, 16'hFFFF);
        send_request(pba_pkg::OP_SET, 16'd2, 16'd0);
        send_request(pba_pkg::OP_ALLOC, 16'd0, 16'd0);      // skips the busy page
        send_request(pba_pkg::OP_SET, 16'd2, 16'd0);        // marking busy again
        send_request(pba_pkg::OP_CLR, 16'd1, 16'd0);
        send_request(pba_pkg::OP_CLR, 16'd1, 16'd0);        // marking free again
        send_request(pba_pkg::OP_ALLOC, 16'd0, 16'd0);      // reuses the freed page
        send_request(pba_pkg::OP_SET, 16'hFFFF, 16'd0);     // last page
        send_request(pba_pkg::OP_CLR, 16'hFFFF, 16'd0);
        send_request(pba_pkg::OP_RANGE, 16'd10, 16'd9);     // reversed range
        send_request(pba_pkg::OP_RANGE, 16'd5, 16'd5);      // one-page range
        send_request(pba_pkg::OP_RANGE, 16'd40, 16'd100);   // spans word boundaries
        send_request(pba_pkg::OP_ALLOC, 16'd0, 16'd0);
        write_total_pages(17'd0);                           // zero pages: all invalid
        send_request(pba_pkg::OP_ALLOC, 16'd0, 16'd0);
        send_request(pba_pkg::OP_SET, 16'd0, 16'd0);
        send_request(pba_pkg::OP_RANGE, 16'd0, 16'd0);
        write_total_pages(17'h1FFFF);                       // oversized count saturates
        send_request(pba_pkg::OP_SET, 16'hFFFF, 16'd0);
        send_request(pba_pkg::OP_RANGE, 16'd0, 16'hFFFF);   // whole map busy
        send_request(pba_pkg::OP_ALLOC, 16'd0, 16'd0);      // no free page
        send_request(pba_pkg::OP_CLR, 16'd777, 16'd0);
        send_request(pba_pkg::OP_ALLOC, 16'd0, 16'd0);      // finds the only hole
        write_total_pages(17'd1);
        send_request(pba_pkg::OP_CLR, 16'd0, 16'd0);
        send_request(pba_pkg::OP_SET, 16'd1, 16'd0);        // page just past the limit
        send_request(pba_pkg::OP_RANGE, 16'd0, 16'd1);      // end out of range
        send_request(pba_pkg::OP_ALLOC, 16'd0, 16'd0);
        send_request(pba_pkg::OP_ALLOC, 16'd0, 16'd0);      // single page exhausted
    endtask

    // Sender holds off until everything is back, then resumes.
    task automatic test_pause_until_drained();
        write_total_pages(17'd65536);
        send_request(pba_pkg::OP_RANGE, 16'd0, 16'hFFFF);
        send_request(pba_pkg::OP_CLR, 16'd100, 16'd0);
        drain_results();
        send_request(pba_pkg::OP_ALLOC, 16'd0, 16'd0);
        send_request(pba_pkg::OP_ALLOC, 16'd0, 16'd0);
        // Free some pages so later phases see a mix of free and busy pages.
        for (int i = 0; i < 30; i++)
            send_request(pba_pkg::OP_CLR, 16'($urandom_range(0, 200)), 16'd0);
    endtask

    // Random mix of requests under one setting of page count and idling.
    task automatic test_random_phase(logic [pba_pkg::CntW-1:0] count, int send_pct,
                                     int stall_pct, int n_items);
        logic [15:0] start_page;
        logic [15:0] stop_page;
        int unsigned roll;
        write_total_pages(count);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            roll       = $urandom_range(0, 99);
            start_page = pick_page();
            if (roll < 35) begin
                send_request(pba_pkg::OP_ALLOC, 16'($urandom()), 16'($urandom()));
            end else if (roll < 55) begin
                send_request(pba_pkg::OP_SET, start_page, 16'($urandom()));
            end else if (roll < 85) begin
                send_request(pba_pkg::OP_CLR, start_page, 16'($urandom()));
            end else begin
                // Mostly short ranges; some with a random end and some reversed.
                case ($urandom_range(0, 19))
                    0:       stop_page = 16'($urandom());
                    1:       stop_page = (start_page == 16'd0) ? 16'd0
                                                                : start_page - 16'd1;
                    default: stop_page = (start_page > 16'hFFFF - 40) ? 16'hFFFF :
                                         start_page + 16'($urandom_range(0, 40));
                endcase
                send_request(pba_pkg::OP_RANGE, start_page, stop_page);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_ready            = 1'b0;
        i_op               = pba_pkg::OP_ALLOC;
        i_page             = '0;
        i_end_page         = '0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        fail_count         = 0;
        total_pages_shadow = 17'd65536;
        foreach (busy_pages[p]) busy_pages[p] = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_pause_until_drained();
        test_random_phase(17'd65536, 0, 0, 450);
        test_random_phase(17'd48, 69, 0, 450);        // small map: frequent exhaustion
        test_random_phase(17'h1FFFF, 0, 69, 450);
        test_random_phase(17'($urandom_range(1, 300)), 13, 13, 450);

        drain_results();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

/* files.f */
rtl/core/pba_pkg.sv
rtl/core/pba_map_ram.sv
rtl/core/page_bitmap_allocator_unit.sv
test/page_bitmap_allocator_unit_tb.sv
